@@ sv/tiep_pkg.sv @@
// ----------------------------------------------------------------------------
// tiep_pkg
// shared types, constants and helper functions for the image file directory
// entry parser core and its checker
// ----------------------------------------------------------------------------
package tiep_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIG_ENDIAN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_OFFSET = 1'b1;
    localparam int CFG_DATA_W = 32;

    // directory layout in bytes
    localparam int COUNT_BYTES = 2;
    localparam int ENTRY_BYTES = 12;
    localparam int NEXT_BYTES  = 4;
    localparam int POS_W       = 4;

    // result kinds
    localparam logic KIND_ENTRY   = 1'b0;
    localparam logic KIND_TRAILER = 1'b1;

    // parse phase
    typedef enum logic [1:0] {
        PH_COUNT = 2'd0,
        PH_ENTRY = 2'd1,
        PH_NEXT  = 2'd2
    } phase_t;

    // input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } in_t;

    // result beat
    typedef struct packed {
        logic        kind;
        logic [15:0] entry_index;
        logic [15:0] tag;
        logic [15:0] format_type;
        logic [31:0] value_count;
        logic [31:0] value_word;
        logic [34:0] byte_size;
        logic        inline_flag;
        logic [31:0] next_offset;
        logic [31:0] base_offset;
        logic [19:0] dir_bytes;
    } out_t;

    // component size in bytes of a format code, zero for unknown codes
    function automatic logic [3:0] fmt_size(input logic [15:0] code);
        logic [3:0] sz;
        sz = 4'd0;
        unique case (code)
            16'd1, 16'd2, 16'd6, 16'd7: sz = 4'd1;
            16'd3, 16'd8:               sz = 4'd2;
            16'd4, 16'd9, 16'd11:       sz = 4'd4;
            16'd5, 16'd10, 16'd12:      sz = 4'd8;
            default:                    sz = 4'd0;
        endcase
        return sz;
    endfunction

    // 16-bit word from two bytes in stream order
    function automatic logic [15:0] word16(input logic [7:0] b0, input logic [7:0] b1,
                                           input logic be);
        return be ? {b0, b1} : {b1, b0};
    endfunction

    // 32-bit word from four bytes in stream order
    function automatic logic [31:0] word32(input logic [7:0] b0, input logic [7:0] b1,
                                           input logic [7:0] b2, input logic [7:0] b3,
                                           input logic be);
        return be ? {b0, b1, b2, b3} : {b3, b2, b1, b0};
    endfunction

endpackage

@@ sv/tiff_ifd_entry_parser_core.sv @@
// ----------------------------------------------------------------------------
// tiff_ifd_entry_parser_core
// byte-serial parser for one image file directory: entry records and trailer
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one directory byte per beat, plus a
//   restart flag that drops any partial parse and starts a new count.
//   out_valid/out_stall/out_data carry at most one result per input beat:
//   an entry record on the last byte of each 12-byte entry, a trailer on the
//   last byte of the 4-byte next pointer.
//   cfg_we/cfg_index/cfg_data write the byte order and the known directory
//   offset; write them only while the block is idle.
// Timing:
//   one byte is taken every cycle while in_stall is low; a result is registered
//   in the result register, or in the skid stage behind a stalled one. All parsing
//   is one combinational pass between the parse state registers and the result register.
// Reset:
//   byte order little-endian, directory offset 0, parser in count phase,
//   result register and skid stage empty.
// Stall:
//   a stalled result holds on out_data; one more result is caught in a skid
//   stage, and in_stall is raised while that stage is full.
// ----------------------------------------------------------------------------
module tiff_ifd_entry_parser_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  tiep_pkg::in_t                       in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output tiep_pkg::out_t                      out_data,
    input  logic                                cfg_we,
    input  logic [tiep_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tiep_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // configuration registers
    logic        be_reg;
    logic [31:0] dir_offset_reg;

    // parse state
    tiep_pkg::phase_t                phase_reg, phase_next, phase_eff;
    logic [tiep_pkg::POS_W-1:0]      pos_reg, pos_next, pos_eff;
    logic [15:0]                     total_reg, total_next;
    logic [15:0]                     done_reg, done_next;
    logic [31:0]                     min_reg, min_next;
    logic                            have_min_reg, have_min_next;
    logic [7:0]                      field_reg [tiep_pkg::ENTRY_BYTES];
    logic [7:0]                      cur      [tiep_pkg::ENTRY_BYTES];

    // result path
    tiep_pkg::out_t                  res;
    logic                            emit;
    logic                            accept;
    logic                            last_byte;
    logic                            out_valid_reg, out_valid_next;
    tiep_pkg::out_t                  out_data_reg, out_data_next;
    logic                            skid_valid_reg, skid_valid_next;
    tiep_pkg::out_t                  skid_data_reg, skid_data_next;

    // decoded words
    logic [15:0] count_word;
    logic [15:0] tag_word;
    logic [15:0] type_word;
    logic [31:0] cnt_word;
    logic [31:0] val_word;
    logic [31:0] next_word;
    logic [3:0]  fsz;
    logic [34:0] size;
    logic [15:0] done_inc;
    logic [19:0] dbytes;
    logic [31:0] base;

    assign accept    = in_valid && !in_stall;
    assign phase_eff = in_data.restart ? tiep_pkg::PH_COUNT : phase_reg;
    assign pos_eff   = in_data.restart ? '0 : pos_reg;

    // stored bytes with the incoming byte placed at its position
    always_comb
    begin
        for (int i = 0; i < tiep_pkg::ENTRY_BYTES; i++)
        begin
            cur[i] = (pos_eff == tiep_pkg::POS_W'(i)) ? in_data.data_byte : field_reg[i];
        end
    end

    // word assembly in the byte order in force now
    assign count_word = tiep_pkg::word16(cur[0], cur[1], be_reg);
    assign tag_word   = tiep_pkg::word16(cur[0], cur[1], be_reg);
    assign type_word  = tiep_pkg::word16(cur[2], cur[3], be_reg);
    assign cnt_word   = tiep_pkg::word32(cur[4], cur[5], cur[6], cur[7], be_reg);
    assign val_word   = tiep_pkg::word32(cur[8], cur[9], cur[10], cur[11], be_reg);
    assign next_word  = tiep_pkg::word32(cur[0], cur[1], cur[2], cur[3], be_reg);
    assign fsz        = tiep_pkg::fmt_size(type_word);
    assign done_inc   = done_reg + 16'd1;

    // byte size is the count shifted by the log of the component size
    always_comb
    begin
        unique case (fsz)
            4'd1:    size = {3'b000, cnt_word};
            4'd2:    size = {2'b00, cnt_word, 1'b0};
            4'd4:    size = {1'b0, cnt_word, 2'b00};
            4'd8:    size = {cnt_word, 3'b000};
            default: size = '0;
        endcase
    end

    // directory size and offset guess
    assign dbytes = 20'd6 + {1'b0, total_reg, 3'b000} + {2'b00, total_reg, 2'b00};
    always_comb
    begin
        priority if (dir_offset_reg != 32'd0)
            base = dir_offset_reg;
        else if (have_min_reg)
            base = min_reg - {12'd0, dbytes};
        else
            base = 32'd0;
    end

    // last byte of the current field group
    always_comb
    begin
        unique case (phase_eff)
            tiep_pkg::PH_COUNT: last_byte = (pos_eff == tiep_pkg::POS_W'(tiep_pkg::COUNT_BYTES - 1));
            tiep_pkg::PH_ENTRY: last_byte = (pos_eff == tiep_pkg::POS_W'(tiep_pkg::ENTRY_BYTES - 1));
            tiep_pkg::PH_NEXT:  last_byte = (pos_eff == tiep_pkg::POS_W'(tiep_pkg::NEXT_BYTES - 1));
            default:            last_byte = 1'b0;
        endcase
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            phase_next = phase_eff;
            unique case (phase_eff)
                tiep_pkg::PH_COUNT:
                begin
                    if (last_byte)
                        phase_next = (count_word == 16'd0) ? tiep_pkg::PH_NEXT
                                                           : tiep_pkg::PH_ENTRY;
                end
                tiep_pkg::PH_ENTRY:
                begin
                    if (last_byte && done_inc >= total_reg)
                        phase_next = tiep_pkg::PH_NEXT;
                end
                tiep_pkg::PH_NEXT:
                begin
                    if (last_byte)
                        phase_next = tiep_pkg::PH_COUNT;
                end
                default: phase_next = tiep_pkg::PH_COUNT;
            endcase
        end
    end

    // counters, running minimum and result
    always_comb
    begin
        pos_next      = pos_reg;
        total_next    = total_reg;
        done_next     = done_reg;
        min_next      = min_reg;
        have_min_next = have_min_reg;
        emit          = 1'b0;
        res           = '0;
        if (accept)
        begin
            pos_next = last_byte ? '0 : pos_eff + tiep_pkg::POS_W'(1);
            if (in_data.restart)
            begin
                min_next      = 32'd0;
                have_min_next = 1'b0;
            end
            unique case (phase_eff)
                tiep_pkg::PH_COUNT:
                begin
                    if (last_byte)
                    begin
                        total_next = count_word;
                        done_next  = 16'd0;
                    end
                end
                tiep_pkg::PH_ENTRY:
                begin
                    if (last_byte)
                    begin
                        emit            = 1'b1;
                        res.kind        = tiep_pkg::KIND_ENTRY;
                        res.entry_index = done_reg;
                        res.tag         = tag_word;
                        res.format_type = type_word;
                        res.value_count = cnt_word;
                        res.value_word  = val_word;
                        res.byte_size   = size;
                        res.inline_flag = (size <= 35'd4);
                        done_next       = done_inc;
                        if (size > 35'd4 && (!have_min_reg || val_word < min_reg))
                        begin
                            min_next      = val_word;
                            have_min_next = 1'b1;
                        end
                    end
                end
                tiep_pkg::PH_NEXT:
                begin
                    if (last_byte)
                    begin
                        emit            = 1'b1;
                        res.kind        = tiep_pkg::KIND_TRAILER;
                        res.entry_index = total_reg;
                        res.next_offset = next_word;
                        res.base_offset = base;
                        res.dir_bytes   = dbytes;
                        total_next      = 16'd0;
                        done_next       = 16'd0;
                        min_next        = 32'd0;
                        have_min_next   = 1'b0;
                    end
                end
                default: pos_next = '0;
            endcase
        end
    end

    // result register with skid stage
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = emit;
                out_data_next  = res;
            end
        end
        else if (emit)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            be_reg         <= 1'b0;
            dir_offset_reg <= 32'd0;
            phase_reg      <= tiep_pkg::PH_COUNT;
            pos_reg        <= '0;
            total_reg      <= 16'd0;
            done_reg       <= 16'd0;
            min_reg        <= 32'd0;
            have_min_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    tiep_pkg::CFG_BIG_ENDIAN: be_reg         <= cfg_data[0];
                    tiep_pkg::CFG_DIR_OFFSET: dir_offset_reg <= cfg_data;
                    default:                  be_reg         <= be_reg;
                endcase
            end
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            total_reg      <= total_next;
            done_reg       <= done_next;
            min_reg        <= min_next;
            have_min_reg   <= have_min_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
        if (accept && pos_eff < tiep_pkg::POS_W'(tiep_pkg::ENTRY_BYTES))
            field_reg[pos_eff] <= in_data.data_byte;
    end

    assign in_stall  = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ sv/tiep_checker.sv @@
// ----------------------------------------------------------------------------
// tiep_checker
// port-level checks for the directory entry parser core
// ----------------------------------------------------------------------------
module tiep_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_stall,
    input logic           out_valid,
    input logic           out_stall,
    input tiep_pkg::out_t out_data
);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result beat changed");

    // input stalls only behind a waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result waiting");

    // input stall starts only after a result was held back
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("input stall without output stall");

    // trailer size follows from the entry count
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == tiep_pkg::KIND_TRAILER |->
            out_data.dir_bytes == 20'd6 + 20'd12 * {4'd0, out_data.entry_index})
        else $error("trailer directory size mismatch");

    // inline flag agrees with byte size in entry records
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == tiep_pkg::KIND_ENTRY |->
            out_data.inline_flag == (out_data.byte_size <= 35'd4))
        else $error("inline flag mismatch");

endmodule

bind tiff_ifd_entry_parser_core tiep_checker u_tiep_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
